@@ hw/rtl/gfsc_pkg.sv @@
`timescale 1ns / 1ps

package gfsc_pkg;

   localparam int WORD_W         = 32;
   localparam int DIM_W          = 9;
   localparam int NUM_DIMS       = 4;
   localparam int DIM_IDX_W      = 2;
   localparam int WORDS_PER_SITE = 72;
   localparam int HEADER_WORDS   = 24;
   localparam int COORD_BITS     = 8;
   localparam int HIDX_W         = 5;
   localparam int ELEM_W         = 7;
   localparam int ROT_W          = 5;
   localparam int STATUS_W       = 3;
   localparam int EXT_W          = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = 1;
   localparam int QCNT_W         = 2;

   localparam logic [WORD_W-1:0] MAGIC_WORD = 32'd20103;
   localparam logic [ROT_W-1:0]  ROT_A_LAST = ROT_W'(28);
   localparam logic [ROT_W-1:0]  ROT_B_LAST = ROT_W'(30);
   localparam logic [HIDX_W-1:0] HDR_MAGIC      = HIDX_W'(0);
   localparam logic [HIDX_W-1:0] HDR_DIM_FIRST  = HIDX_W'(1);
   localparam logic [HIDX_W-1:0] HDR_DIM_LAST   = HIDX_W'(4);
   localparam logic [HIDX_W-1:0] HDR_DATE_FIRST = HIDX_W'(5);
   localparam logic [HIDX_W-1:0] HDR_DATE_LAST  = HIDX_W'(20);
   localparam logic [HIDX_W-1:0] HDR_SUM_A      = HIDX_W'(22);
   localparam logic [HIDX_W-1:0] HDR_SUM_B      = HIDX_W'(23);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY         = 3'd0,
      ST_OK           = 3'd1,
      ST_BAD_MAGIC    = 3'd2,
      ST_DIM_MISMATCH = 3'd3,
      ST_SUM_MISMATCH = 3'd4
   } status_type;

   typedef struct packed {
      logic [WORD_W-1:0] raw;
      logic [WORD_W-1:0] swapped;
      logic              start;
      logic              magic_raw;
      logic              magic_swapped;
   } word_info_type;

   function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] w,
                                                 input logic [ROT_W-1:0]  r);
      logic [ROT_W:0] back;
      back = 6'd32 - {1'b0, r};
      return (w << r) | (w >> back);
   endfunction

   function automatic logic [EXT_W-1:0] extent_of(input logic [DIM_W-1:0] dim);
      logic [EXT_W-1:0] lim;
      logic [EXT_W-1:0] e;
      lim = EXT_W'(1) << COORD_BITS;
      e   = EXT_W'(dim);
      return (e > lim) ? lim : e;
   endfunction

endpackage

@@ hw/rtl/gfsc_front.sv @@
`timescale 1ns / 1ps

module gfsc_front import gfsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_word_in,
   input  logic                req_start_req,
   input  logic                q_pop,
   output logic                q_valid,
   output word_info_type       q_info
);

   word_info_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]          count_ff, count_in;
   word_info_type              info;
   logic                       push;
   logic                       pop;

   // classify the incoming word
   always_comb begin
      info.raw           = req_word_in;
      info.swapped       = bswap32(req_word_in);
      info.start         = req_start_req;
      info.magic_raw     = (req_word_in == MAGIC_WORD);
      info.magic_swapped = (bswap32(req_word_in) == MAGIC_WORD);
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;
   assign q_valid   = (count_ff != '0);
   assign q_info    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= info;
      end
   end

endmodule

@@ hw/rtl/gfsc_back.sv @@
`timescale 1ns / 1ps

module gfsc_back import gfsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [DIM_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wr_data,
   input  logic                 q_valid,
   input  word_info_type        q_info,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_word_out,
   output logic                 rsp_is_data,
   output logic [STATUS_W-1:0]  rsp_status
);

   logic [DIM_W-1:0]      dim_ff [NUM_DIMS];
   phase_type             phase_ff, phase_in;
   logic [HIDX_W-1:0]     hidx_ff, hidx_in;
   logic                  swap_ff, swap_in;
   logic [WORD_W-1:0]     exp_a_ff, exp_a_in;
   logic [WORD_W-1:0]     exp_b_ff, exp_b_in;
   logic [WORD_W-1:0]     sum_a_ff, sum_a_in;
   logic [WORD_W-1:0]     sum_b_ff, sum_b_in;
   logic [ROT_W-1:0]      rot_a_ff, rot_a_in;
   logic [ROT_W-1:0]      rot_b_ff, rot_b_in;
   logic [ELEM_W-1:0]     elem_ff, elem_in;
   logic [COORD_BITS-1:0] coord_ff [NUM_DIMS];
   logic [COORD_BITS-1:0] coord_in [NUM_DIMS];
   status_type            final_ff, final_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic                  rsp_data_ff, rsp_data_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  take;

   assign take      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;
   assign rsp_is_data  = rsp_data_ff;
   assign rsp_status   = rsp_status_ff;

   always_comb begin
      phase_type         ph;
      logic [HIDX_W-1:0] h;
      logic [HIDX_W-1:0] h_next;
      logic              sw;
      logic [WORD_W-1:0] w;
      logic              carry;
      logic              empty_vol;
      logic [EXT_W-1:0]  inc;
      logic [ELEM_W-1:0] e_next;

      phase_in = phase_ff;
      hidx_in  = hidx_ff;
      swap_in  = swap_ff;
      exp_a_in = exp_a_ff;
      exp_b_in = exp_b_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      rot_a_in = rot_a_ff;
      rot_b_in = rot_b_ff;
      elem_in  = elem_ff;
      coord_in = coord_ff;
      final_in = final_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_stall ? rsp_valid_ff : 1'b0;
      ph        = phase_ff;
      h         = hidx_ff;
      h_next    = hidx_ff;
      sw        = swap_ff;
      w         = '0;
      carry     = 1'b0;
      empty_vol = 1'b0;
      inc       = '0;
      e_next    = '0;

      if (take) begin
         rsp_valid_in = 1'b1;
         // restart on a new file
         if (q_info.start) begin
            phase_in = PH_HEADER;
            hidx_in  = '0;
            swap_in  = 1'b0;
            exp_a_in = '0;
            exp_b_in = '0;
            sum_a_in = '0;
            sum_b_in = '0;
            rot_a_in = '0;
            rot_b_in = '0;
            elem_in  = '0;
            for (int d = 0; d < NUM_DIMS; d++) begin
               coord_in[d] = '0;
            end
            final_in = ST_BUSY;
         end
         ph = phase_in;
         h  = hidx_in;
         sw = swap_in;
         w  = sw ? q_info.swapped : q_info.raw;
         rsp_data_in = 1'b0;

         unique case (ph)
            PH_HEADER: begin
               if (h == HDR_MAGIC) begin
                  if (q_info.magic_raw) begin
                     swap_in = 1'b0;
                     w       = q_info.raw;
                  end else if (q_info.magic_swapped) begin
                     swap_in = 1'b1;
                     w       = MAGIC_WORD;
                  end else begin
                     w        = q_info.raw;
                     final_in = ST_BAD_MAGIC;
                     phase_in = PH_DONE;
                  end
               end else if (h >= HDR_DIM_FIRST && h <= HDR_DIM_LAST) begin
                  if (w != WORD_W'(dim_ff[DIM_IDX_W'(h - HDR_DIM_FIRST)])) begin
                     final_in = ST_DIM_MISMATCH;
                     phase_in = PH_DONE;
                  end
               end else if (h >= HDR_DATE_FIRST && h <= HDR_DATE_LAST) begin
                  w = q_info.raw;
               end else if (h == HDR_SUM_A) begin
                  exp_a_in = w;
               end else if (h == HDR_SUM_B) begin
                  exp_b_in = w;
               end
               if (phase_in == PH_HEADER) begin
                  h_next  = h + 1'b1;
                  hidx_in = h_next;
                  if (h_next >= HIDX_W'(HEADER_WORDS)) begin
                     sum_a_in = '0;
                     sum_b_in = '0;
                     rot_a_in = '0;
                     rot_b_in = '0;
                     elem_in  = '0;
                     for (int d = 0; d < NUM_DIMS; d++) begin
                        coord_in[d] = '0;
                        if (extent_of(dim_ff[d]) == '0) begin
                           empty_vol = 1'b1;
                        end
                     end
                     if (empty_vol) begin
                        final_in = (exp_a_in == '0 && exp_b_in == '0) ? ST_OK
                                                                      : ST_SUM_MISMATCH;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               rsp_status_in = (phase_in == PH_DONE) ? final_in : ST_BUSY;
            end
            PH_DATA: begin
               rsp_data_in = 1'b1;
               sum_a_in = sum_a_in ^ rotl32(w, rot_a_in);
               sum_b_in = sum_b_in ^ rotl32(w, rot_b_in);
               rot_a_in = (rot_a_in == ROT_A_LAST) ? '0 : rot_a_in + 1'b1;
               rot_b_in = (rot_b_in == ROT_B_LAST) ? '0 : rot_b_in + 1'b1;
               e_next   = elem_in + 1'b1;
               elem_in  = e_next;
               if (ELEM_W'(e_next) >= ELEM_W'(WORDS_PER_SITE)) begin
                  elem_in = '0;
                  carry   = 1'b1;
                  for (int d = 0; d < NUM_DIMS; d++) begin
                     if (carry) begin
                        inc = EXT_W'(coord_in[d]) + 1'b1;
                        if (inc >= extent_of(dim_ff[d])) begin
                           coord_in[d] = '0;
                        end else begin
                           coord_in[d] = coord_in[d] + 1'b1;
                           carry       = 1'b0;
                        end
                     end
                  end
                  if (carry) begin
                     final_in = (sum_a_in == exp_a_in && sum_b_in == exp_b_in) ? ST_OK
                                                                            : ST_SUM_MISMATCH;
                     phase_in = PH_DONE;
                  end
               end
               rsp_status_in = (phase_in == PH_DONE) ? final_in : ST_BUSY;
            end
            default: begin
               rsp_status_in = final_in;
            end
         endcase
         rsp_word_in = w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) begin
            dim_ff[d]   <= DIM_W'(1);
            coord_ff[d] <= '0;
         end
         phase_ff     <= PH_HEADER;
         hidx_ff      <= '0;
         swap_ff      <= 1'b0;
         exp_a_ff     <= '0;
         exp_b_ff     <= '0;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         rot_a_ff     <= '0;
         rot_b_ff     <= '0;
         elem_ff      <= '0;
         final_ff     <= ST_BUSY;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            dim_ff[csr_index] <= csr_wr_data;
         end
         coord_ff     <= coord_in;
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         swap_ff      <= swap_in;
         exp_a_ff     <= exp_a_in;
         exp_b_ff     <= exp_b_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         rot_a_ff     <= rot_a_in;
         rot_b_ff     <= rot_b_in;
         elem_ff      <= elem_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff   <= rsp_word_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ hw/rtl/gauge_file_stream_checker.sv @@
// channel | ports                                         | direction
// req     | req_valid, req_stall, req_word_in, req_start_req | in
// rsp     | rsp_valid, rsp_stall, rsp_word_out, rsp_is_data, rsp_status | out
// csr     | csr_wr_en, csr_index, csr_wr_data             | in
//
// one word a cycle sustained while rsp_stall is low; a word taken on req passes
// through the two-entry input queue and then the output register before rsp
// all parse and checksum state updates in back stage, a word per unstalled cycle
// synchronous reset clears the queue, the parser state and the extents to 1
// req_stall rises only when the queue holds two words; rsp_stall backs up into it
`timescale 1ns / 1ps

module gauge_file_stream_checker import gfsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_W-1:0]    req_word_in,
   input  logic                 req_start_req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_W-1:0]    rsp_word_out,
   output logic                 rsp_is_data,
   output logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_wr_en,
   input  logic [DIM_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wr_data
);

   logic          q_valid;
   logic          q_pop;
   word_info_type q_info;

   gfsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word_in   (req_word_in),
      .req_start_req (req_start_req),
      .q_pop         (q_pop),
      .q_valid       (q_valid),
      .q_info        (q_info)
   );

   gfsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .q_valid      (q_valid),
      .q_info       (q_info),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word_out (rsp_word_out),
      .rsp_is_data  (rsp_is_data),
      .rsp_status   (rsp_status)
   );

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_data |->
         rsp_status == ST_BUSY || rsp_status == ST_OK || rsp_status == ST_SUM_MISMATCH)
      else $error("payload word with header error status");

   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

endmodule
